[rtl/arw_pkg.sv]
// Shared constants, types and helpers for the anti-replay window check.
// Used by the channel interfaces, the controller, the datapath and the top level.
package arw_pkg;

  localparam int WINDOW_BITS = 1024;
  localparam int CTR_W       = 64;
  localparam int SLOT_W      = $clog2(WINDOW_BITS);
  localparam int WORD_W      = (WINDOW_BITS < 64) ? WINDOW_BITS : 64;
  localparam int BIT_W       = $clog2(WORD_W);
  localparam int ROWS        = WINDOW_BITS / WORD_W;
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef enum logic [1:0] {
    ST_ACCEPT  = 2'd0,
    ST_OLD     = 2'd1,
    ST_DUP     = 2'd2,
    ST_CLEARED = 2'd3
  } arw_status_t;

  typedef logic [CTR_W-1:0]  ctr_t;
  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [ROW_AW-1:0] row_t;
  typedef logic [BIT_W-1:0]  bit_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic load;
    logic start_mark;
    logic start_skip;
    logic set_hi;
    logic clr_any;
    logic chk;
    logic wr;
    logic step;
    logic sweep_start;
    logic sweep_wr;
    logic sweep_mark;
  } arw_cmd_t;

  typedef struct packed {
    logic first;
    logic gt;
    logic far_fwd;
    logic far_bwd;
    logic dup;
    logic last;
    logic sw_last;
  } arw_sts_t;

  function automatic row_t row_of(slot_t s);
    return row_t'(s >> BIT_W);
  endfunction

  function automatic bit_t bit_of(slot_t s);
    return s[BIT_W-1:0];
  endfunction

endpackage

[rtl/arw_if.sv]
// Valid/ready channel interfaces for the anti-replay window check.
// Depends on arw_pkg for field widths.
interface arw_in_if import arw_pkg::*; ();
  logic valid;
  logic ready;
  logic op;
  ctr_t pkt_counter;

  modport source (output valid, output op, output pkt_counter, input ready);
  modport sink (input valid, input op, input pkt_counter, output ready);
endinterface

interface arw_out_if import arw_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;

  modport source (output valid, output status, input ready);
  modport sink (input valid, input status, output ready);
endinterface

[rtl/arw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No package dependency.
module arw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/arw_dp.sv]
// Datapath: counter compare, window state and the bitmap RAM with its
// read-modify-write and sweep logic. Depends on arw_pkg and arw_ram.
module arw_dp import arw_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  ctr_t     in_pkt_counter,
  input  arw_cmd_t cmd,
  output arw_sts_t sts
);

  ctr_t           ctr_r;
  logic [CTR_W:0] fwd_r;
  ctr_t           bwd_r;
  ctr_t           hi_r;
  logic           any_r;
  slot_t          cur_r;
  slot_t          cur_nxt;
  slot_t          rem_r;
  slot_t          rem_nxt;
  row_t           sw_r;

  word_t          rd_data;
  word_t          rmw_data;
  word_t          sweep_data;
  word_t          clr_mask;
  logic           ram_we;
  row_t           ram_waddr;
  word_t          ram_wdata;

  bit_t           b;
  bit_t           tgt;
  logic [BIT_W:0] avail;
  logic [BIT_W:0] k;
  logic           last;
  logic           dup;

  assign b     = bit_of(cur_r);
  assign avail = (BIT_W+1)'(WORD_W) - {1'b0, b};
  assign last  = {1'b0, rem_r} < (SLOT_W+1)'(avail);
  assign k     = last ? (BIT_W+1)'(rem_r) : avail;
  assign tgt   = b + bit_t'(rem_r);
  assign dup   = rd_data[b];

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      clr_mask[i] = ((BIT_W+2)'(i) >= (BIT_W+2)'(b)) &&
                    ((BIT_W+2)'(i) < (BIT_W+2)'(b) + (BIT_W+2)'(k));
    end
  end

  assign rmw_data   = (rd_data & ~clr_mask) | (last ? (word_t'(1) << tgt) : '0);
  assign sweep_data = (cmd.sweep_mark && (sw_r == row_of(ctr_r[SLOT_W-1:0]))) ?
                      (word_t'(1) << bit_of(ctr_r[SLOT_W-1:0])) : '0;

  always_comb begin
    cur_nxt = cur_r;
    rem_nxt = rem_r;
    if (cmd.start_mark) begin
      cur_nxt = ctr_r[SLOT_W-1:0];
      rem_nxt = '0;
    end else if (cmd.start_skip) begin
      cur_nxt = hi_r[SLOT_W-1:0] + SLOT_W'(1);
      rem_nxt = fwd_r[SLOT_W-1:0] - SLOT_W'(1);
    end else if (cmd.step) begin
      cur_nxt = (cur_r | SLOT_W'(WORD_W - 1)) + SLOT_W'(1);
      rem_nxt = rem_r - SLOT_W'(avail);
    end
  end

  assign ram_we    = cmd.sweep_wr | (cmd.wr & ~(cmd.chk & dup));
  assign ram_waddr = cmd.sweep_wr ? sw_r : row_of(cur_r);
  assign ram_wdata = cmd.sweep_wr ? sweep_data : rmw_data;

  arw_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ROWS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (row_of(cur_nxt)),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ctr_r <= in_pkt_counter;
      fwd_r <= {1'b0, in_pkt_counter} - {1'b0, hi_r};
      bwd_r <= hi_r - in_pkt_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hi_r  <= '0;
      any_r <= 1'b0;
      cur_r <= '0;
      rem_r <= '0;
      sw_r  <= '0;
    end else begin
      cur_r <= cur_nxt;
      rem_r <= rem_nxt;
      if (cmd.set_hi) begin
        hi_r  <= ctr_r;
        any_r <= 1'b1;
      end else if (cmd.clr_any) begin
        any_r <= 1'b0;
      end
      if (cmd.sweep_start) begin
        sw_r <= '0;
      end else if (cmd.sweep_wr) begin
        sw_r <= sw_r + row_t'(1);
      end
    end
  end

  assign sts.first   = ~any_r;
  assign sts.gt      = ~fwd_r[CTR_W] && (fwd_r[CTR_W-1:0] != '0);
  assign sts.far_fwd = fwd_r[CTR_W-1:SLOT_W] != '0;
  assign sts.far_bwd = bwd_r[CTR_W-1:SLOT_W] != '0;
  assign sts.dup     = dup;
  assign sts.last    = last;
  assign sts.sw_last = sw_r == row_t'(ROWS - 1);

endmodule

[rtl/arw_ctrl.sv]
// Controller: sequences classify, read-modify-write and sweep steps and holds
// the output word register. Depends on arw_pkg.
module arw_ctrl import arw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output arw_cmd_t    cmd,
  input  arw_sts_t    sts
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLASSIFY,
    S_RD,
    S_RMW,
    S_SWEEP,
    S_DONE
  } state_t;

  state_t      state_r;
  logic        chk_r;
  logic        mark_r;
  arw_status_t status_r;
  logic        out_valid_r;
  arw_status_t out_status_r;
  logic        in_fire;
  logic        out_free;

  assign in_ready   = state_r == S_IDLE;
  assign in_fire    = in_valid && in_ready;
  assign out_free   = ~out_valid_r || out_ready;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;

  always_comb begin
    cmd            = '0;
    cmd.chk        = chk_r;
    cmd.sweep_mark = mark_r;
    case (state_r)
      S_INIT: begin
        cmd.sweep_wr = 1'b1;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          if (in_op == OP_CLEAR) begin
            cmd.clr_any     = 1'b1;
            cmd.sweep_start = 1'b1;
          end
        end
      end
      S_CLASSIFY: begin
        if (sts.first) begin
          cmd.start_mark = 1'b1;
          cmd.set_hi     = 1'b1;
        end else if (sts.gt) begin
          cmd.set_hi = 1'b1;
          if (sts.far_fwd) begin
            cmd.sweep_start = 1'b1;
          end else begin
            cmd.start_skip = 1'b1;
          end
        end else if (!sts.far_bwd) begin
          cmd.start_mark = 1'b1;
        end
      end
      S_RMW: begin
        cmd.wr   = 1'b1;
        cmd.step = ~sts.last;
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      chk_r        <= 1'b0;
      mark_r       <= 1'b0;
      status_r     <= ST_ACCEPT;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_ACCEPT;
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r  <= 1'b1;
        out_status_r <= status_r;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_INIT: begin
          if (sts.sw_last) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            if (in_op == OP_CLEAR) begin
              status_r <= ST_CLEARED;
              mark_r   <= 1'b0;
              state_r  <= S_SWEEP;
            end else begin
              state_r <= S_CLASSIFY;
            end
          end
        end
        S_CLASSIFY: begin
          if (sts.first) begin
            chk_r    <= 1'b0;
            status_r <= ST_ACCEPT;
            state_r  <= S_RMW;
          end else if (sts.gt) begin
            chk_r    <= 1'b0;
            status_r <= ST_ACCEPT;
            if (sts.far_fwd) begin
              mark_r  <= 1'b1;
              state_r <= S_SWEEP;
            end else begin
              state_r <= S_RMW;
            end
          end else if (sts.far_bwd) begin
            chk_r    <= 1'b0;
            status_r <= ST_OLD;
            state_r  <= S_DONE;
          end else begin
            chk_r    <= 1'b1;
            status_r <= ST_ACCEPT;
            state_r  <= S_RMW;
          end
        end
        S_RD: begin
          state_r <= S_RMW;
        end
        S_RMW: begin
          if (chk_r && sts.dup) begin
            status_r <= ST_DUP;
          end
          state_r <= sts.last ? S_DONE : S_RD;
        end
        S_SWEEP: begin
          if (sts.sw_last) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_op == OP_CLEAR |=> state_r == S_SWEEP && status_r == ST_CLEARED)
    else $error("clear word did not start a window sweep");

  a_old_reject: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLASSIFY && !sts.first && !sts.gt && sts.far_bwd
    |=> state_r == S_DONE && status_r == ST_OLD)
    else $error("counter behind the window not rejected as too old");

  a_dup_from_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && status_r == ST_DUP |-> chk_r)
    else $error("duplicate reported outside an in-window check");
`endif

endmodule

[rtl/anti_replay_window_check.sv]
// Top level of the anti-replay window check: channel interfaces, controller
// and datapath. Depends on arw_pkg, arw_if, arw_ctrl and arw_dp.
//
// Usage:
//   in_ch carries one word per packet: op (check and mark, or clear window)
//   and the 64-bit pkt_counter. out_ch returns one status word per input
//   word: accepted, too old, duplicate or window cleared.
//   A check inside the window or a first packet goes from accept to output
//   valid through accept, classify, bitmap read-modify-write and output load.
//   An advance by less than a window clears skipped slots one 64-bit bitmap
//   row per read-modify-write pass, with a read and a read-modify-write per extra row.
//   A clear word or an advance by a full window or more sweeps every bitmap
//   row, one per cycle. The single bitmap RAM port pair sets these steps.
//   After reset the block sweeps the bitmap to zero with in_ch.ready low.
//   The output word sits in a register: the next input word is taken while
//   it waits, and work stalls at the output load until out_ch.ready frees it.
module anti_replay_window_check import arw_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  arw_in_if.sink    in_ch,
  arw_out_if.source out_ch
);

  arw_cmd_t cmd;
  arw_sts_t sts;

  arw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_op      (in_ch.op),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .cmd        (cmd),
    .sts        (sts)
  );

  arw_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_pkt_counter (in_ch.pkt_counter),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

[verif/arw_window_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the anti-replay window check: keeps its own bitmap window,
// predicts the status of every accepted packet word and compares the returned
// status words in order. Depends on arw_pkg and the arw_in_if/arw_out_if channels.
module arw_window_checker import arw_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  arw_in_if    in_mon,
  arw_out_if   out_mon,
  output int   fail_count,
  output int   due_count,
  output int   n_accept,
  output int   n_old,
  output int   n_dup,
  output int   n_cleared
);

  bit          seen_map [WINDOW_BITS];
  ctr_t        top_ctr;
  bit          armed;
  arw_status_t status_due [$];

  function automatic int slot_idx(ctr_t ctr);
    return int'(ctr % ctr_t'(WINDOW_BITS));
  endfunction

  function automatic void wipe_window();
    foreach (seen_map[i]) seen_map[i] = 1'b0;
  endfunction

  function automatic arw_status_t replay_verdict(logic op, ctr_t ctr);
    ctr_t c;
    if (op == OP_CLEAR) begin
      wipe_window();
      armed = 1'b0;
      return ST_CLEARED;
    end
    if (!armed) begin
      seen_map[slot_idx(ctr)] = 1'b1;
      top_ctr = ctr;
      armed = 1'b1;
      return ST_ACCEPT;
    end
    if (ctr > top_ctr) begin
      if (ctr - top_ctr >= ctr_t'(WINDOW_BITS)) begin
        wipe_window();
      end else begin
        for (c = top_ctr + 1; c < ctr; c++) seen_map[slot_idx(c)] = 1'b0;
      end
      seen_map[slot_idx(ctr)] = 1'b1;
      top_ctr = ctr;
      return ST_ACCEPT;
    end
    if (top_ctr - ctr >= ctr_t'(WINDOW_BITS)) return ST_OLD;
    if (seen_map[slot_idx(ctr)]) return ST_DUP;
    seen_map[slot_idx(ctr)] = 1'b1;
    return ST_ACCEPT;
  endfunction

  initial begin
    fail_count = 0;
    due_count  = 0;
    n_accept   = 0;
    n_old      = 0;
    n_dup      = 0;
    n_cleared  = 0;
  end

  always @(posedge clk) begin
    arw_status_t want;
    if (!rst_n) begin
      wipe_window();
      top_ctr = '0;
      armed = 1'b0;
      status_due.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (status_due.size() == 0) begin
          $display("%0t: unexpected status word, expected none, actual %b",
                   $time, out_mon.status);
          fail_count++;
        end else begin
          want = status_due.pop_front();
          if (out_mon.status !== want) begin
            $display("%0t: status mismatch, expected %s (%0d), actual %b",
                     $time, want.name(), want, out_mon.status);
            fail_count++;
          end
          case (want)
            ST_ACCEPT:  n_accept++;
            ST_OLD:     n_old++;
            ST_DUP:     n_dup++;
            ST_CLEARED: n_cleared++;
            default: ;
          endcase
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        status_due.push_back(replay_verdict(in_mon.op, in_mon.pkt_counter));
      end
    end
    due_count = status_due.size();
  end

endmodule

[verif/anti_replay_window_check_tb.sv]
`timescale 1ns / 1ps
// Testbench top for the anti-replay window check: clock, reset, packet stimulus
// and output back-pressure, with the verdict taken from arw_window_checker.
// Depends on arw_pkg, arw_if, the block itself and arw_window_checker.
module anti_replay_window_check_tb;
  import arw_pkg::*;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_WORDS = 1050;
  localparam int DRAIN_CYCLES = 2 * ROWS + 40;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   calm  = 1'b0;
  int   cycle_count = 0;
  int   fail_count;
  int   due_count;
  int   n_accept;
  int   n_old;
  int   n_dup;
  int   n_cleared;

  arw_in_if  in_ch ();
  arw_out_if out_ch ();

  anti_replay_window_check u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  arw_window_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .due_count  (due_count),
    .n_accept   (n_accept),
    .n_old      (n_old),
    .n_dup      (n_dup),
    .n_cleared  (n_cleared)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d status words outstanding", $time, due_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic ctr_t rand_ctr();
    return {$urandom, $urandom};
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(logic op, ctr_t ctr);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    repeat (gap) begin
      in_ch.valid       <= 1'b0;
      in_ch.op          <= 1'($urandom_range(0, 1));
      in_ch.pkt_counter <= rand_ctr();
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.pkt_counter <= ctr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    int stall;
    int burst;
    out_ch.ready = 1'b0;
    forever begin
      stall = pick_gap();
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    ctr_t hi_sent;
    ctr_t ctr;
    logic op;
    bit   fresh;
    int   pick;

    in_ch.valid       = 1'b0;
    in_ch.op          = OP_CHECK;
    in_ch.pkt_counter = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    send_word(OP_CHECK, '0);
    send_word(OP_CHECK, '0);
    send_word(OP_CHECK, 5);
    send_word(OP_CHECK, 3);
    send_word(OP_CHECK, 3);
    send_word(OP_CHECK, 5);
    send_word(OP_CHECK, 5 + WINDOW_BITS);
    send_word(OP_CHECK, 5);
    send_word(OP_CHECK, 6);
    send_word(OP_CHECK, 4 + 2 * WINDOW_BITS);
    send_word(OP_CHECK, 6 + WINDOW_BITS);
    send_word(OP_CLEAR, '1);
    send_word(OP_CHECK, '1);
    send_word(OP_CHECK, '1);
    send_word(OP_CHECK, ~ctr_t'(WINDOW_BITS));
    send_word(OP_CHECK, ~ctr_t'(WINDOW_BITS - 1));
    send_word(OP_CLEAR, '0);
    send_word(OP_CHECK, 100);
    send_word(OP_CHECK, 64'h8000_0000_0000_0000);
    send_word(OP_CHECK, '0);
    send_word(OP_CHECK, 64'h5555_5555_5555_5555);
    send_word(OP_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(OP_CLEAR, '0);
    send_word(OP_CHECK, 64'h5555_5555_5555_5555);

    hi_sent = 64'h5555_5555_5555_5555;
    fresh   = 1'b0;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 150 == 0) calm = ((i / 150) % 3 == 1);
      pick = $urandom_range(0, 99);
      op   = OP_CHECK;
      if (pick < 3) begin
        op  = OP_CLEAR;
        ctr = rand_ctr();
      end else if (fresh && $urandom_range(0, 1)) begin
        ctr = rand_ctr();
      end else if (pick < 38) begin
        ctr = hi_sent + ctr_t'($urandom_range(1, 8));
      end else if (pick < 48) begin
        ctr = hi_sent + ctr_t'($urandom_range(9, WINDOW_BITS - 1));
      end else if (pick < 53) begin
        case ($urandom_range(0, 3))
          0:       ctr = hi_sent + ctr_t'(WINDOW_BITS);
          1:       ctr = hi_sent + ctr_t'(WINDOW_BITS - 1);
          2:       ctr = hi_sent - ctr_t'(WINDOW_BITS);
          default: ctr = hi_sent - ctr_t'(WINDOW_BITS - 1);
        endcase
      end else if (pick < 58) begin
        ctr = hi_sent + (rand_ctr() >> $urandom_range(0, 63));
      end else if (pick < 86) begin
        ctr = hi_sent - ctr_t'($urandom_range(0, WINDOW_BITS - 1));
      end else if (pick < 94) begin
        ctr = hi_sent - ctr_t'(WINDOW_BITS) - ctr_t'($urandom_range(0, 5000));
      end else begin
        ctr = rand_ctr();
      end
      send_word(op, ctr);
      if (op == OP_CLEAR) begin
        fresh = 1'b1;
      end else begin
        if (fresh || ctr > hi_sent) hi_sent = ctr;
        fresh = 1'b0;
      end
    end

    calm = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d packet and clear words over %0d cycles, %0d mismatches.",
             n_accept + n_old + n_dup + n_cleared, cycle_count, fail_count);
    $display("Status mix: %0d accepted, %0d too old, %0d duplicate, %0d window cleared.",
             n_accept, n_old, n_dup, n_cleared);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
